/* sv/slrm_pkg.sv */
// Shared types and constants of the sliding-window RMS level meter.
package slrm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int SQ_W       = 2 * SAMPLE_W - 1;
    localparam int SUM_W      = 43;
    localparam int CFG_W      = 13;
    localparam int LEVEL_W    = 16;
    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(1024);

    localparam int LOG_IN_W   = 64;
    localparam int LZ_W       = 6;
    localparam int FRAC_W     = 16;
    localparam int LOG_W      = LZ_W + FRAC_W;
    localparam int MANT_W     = 31;
    localparam int NORM_STEPS = 6;
    localparam int CNT_W      = 4;

    localparam int T_W        = LOG_W + 2;
    localparam int KDB_W      = 27;
    localparam int PROD_W     = T_W + KDB_W;
    localparam int LVL_FULL_W = PROD_W + 1 - FRAC_W;

    localparam logic signed [T_W-1:0]        T_OFS    = T_W'(2 * (SAMPLE_W - 1) * (1 << FRAC_W));
    localparam logic signed [KDB_W-1:0]      KDB      = KDB_W'(50504453);
    localparam logic [PROD_W:0]              LVL_BIAS = (PROD_W + 1)'(50504453 + 32768);
    localparam logic signed [LVL_FULL_W-1:0] LEVEL_LO = LVL_FULL_W'(-32768);
    localparam logic signed [LVL_FULL_W-1:0] LEVEL_HI = LVL_FULL_W'(1024);

    typedef enum logic [3:0] {
        S_WSTART,
        S_WWAIT,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_CHECK,
        S_LWAIT,
        S_DIFF,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic read;
        logic update;
        logic log_start;
        logic log_sel_w;
        logic save_log_w;
        logic calc_t;
        logic calc_prod;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic log_done;
        logic sum_zero;
        logic out_full;
    } t_status;

endpackage

/* sv/slrm_log2.sv */
// Iterative log2 unit: binary normalizer, then one squaring step per fraction bit (Q16 result).
module slrm_log2
    import slrm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [LOG_IN_W-1:0] i_x,
    output logic                o_done,
    output logic [LOG_W-1:0]    o_result
);

    logic                r_busy;
    logic                r_iter;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [LOG_IN_W-1:0] r_x;
    logic [LZ_W-1:0]     r_lz;
    logic [MANT_W-1:0]   r_y;
    logic [FRAC_W-1:0]   r_frac;

    logic                hit;
    logic [LOG_IN_W-1:0] sh;
    logic [LZ_W-1:0]     amt;
    logic [LOG_IN_W-1:0] n_x;
    logic [LZ_W-1:0]     n_lz;
    logic [2*MANT_W-1:0] sqr;
    logic [MANT_W:0]     top;
    logic [MANT_W-1:0]   n_y;

    always_comb begin
        case (r_cnt[2:0])
            3'd0: begin
                hit = (r_x[LOG_IN_W-1 -: 32] == '0);
                sh  = r_x << 32;
                amt = LZ_W'(32);
            end
            3'd1: begin
                hit = (r_x[LOG_IN_W-1 -: 16] == '0);
                sh  = r_x << 16;
                amt = LZ_W'(16);
            end
            3'd2: begin
                hit = (r_x[LOG_IN_W-1 -: 8] == '0);
                sh  = r_x << 8;
                amt = LZ_W'(8);
            end
            3'd3: begin
                hit = (r_x[LOG_IN_W-1 -: 4] == '0);
                sh  = r_x << 4;
                amt = LZ_W'(4);
            end
            3'd4: begin
                hit = (r_x[LOG_IN_W-1 -: 2] == '0);
                sh  = r_x << 2;
                amt = LZ_W'(2);
            end
            default: begin
                hit = ~r_x[LOG_IN_W-1];
                sh  = r_x << 1;
                amt = LZ_W'(1);
            end
        endcase
        n_x  = hit ? sh : r_x;
        n_lz = hit ? r_lz + amt : r_lz;
    end

    assign sqr = {{MANT_W{1'b0}}, r_y} * {{MANT_W{1'b0}}, r_y};
    assign top = sqr[2*MANT_W-1 -: MANT_W+1];
    assign n_y = top[MANT_W] ? top[MANT_W:1] : top[MANT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (!r_iter) begin
                    if (r_cnt == CNT_W'(NORM_STEPS - 1)) begin
                        r_iter <= 1'b1;
                        r_cnt  <= '0;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end else begin
                    if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x  <= i_x;
            r_lz <= '0;
        end else if (r_busy && !r_iter) begin
            r_x  <= n_x;
            r_lz <= n_lz;
            if (r_cnt == CNT_W'(NORM_STEPS - 1)) begin
                r_y <= n_x[LOG_IN_W-1 -: MANT_W];
            end
        end else if (r_busy && r_iter) begin
            r_y    <= n_y;
            r_frac <= {r_frac[FRAC_W-2:0], top[MANT_W]};
        end
    end

    assign o_done   = r_done;
    assign o_result = {LZ_W'(LOG_IN_W - 1) - r_lz, r_frac};

    // mantissa stays normalized through the squaring steps
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_iter) |-> r_y[MANT_W-1])
        else $error("log2 mantissa lost its leading one");

endmodule

/* sv/slrm_datapath.sv */
// Datapath: square ring, running sum, log2 unit, dB scaling and output register.
module slrm_datapath
    import slrm_pkg::*;
#(
    parameter int WINDOW_MAX = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_ready,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    output logic                       o_out_valid,
    output logic [SUM_W-1:0]           o_window_sum,
    output logic signed [LEVEL_W-1:0]  o_level_dbfs,
    output logic                       o_silent
);

    localparam int PW = $clog2(WINDOW_MAX);
    localparam int FW = $clog2(WINDOW_MAX + 1);

    logic [SQ_W-1:0] r_ring [WINDOW_MAX];

    logic [CFG_W-1:0]           r_win;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [SQ_W-1:0]            r_sq;
    logic [SQ_W-1:0]            r_rd;
    logic [SUM_W-1:0]           r_sum;
    logic [FW-1:0]              r_fill;
    logic [PW-1:0]              r_wp;
    logic [LOG_W-1:0]           r_log_w;
    logic signed [T_W-1:0]      r_t;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_out_valid;
    logic [SUM_W-1:0]           r_out_sum;
    logic signed [LEVEL_W-1:0]  r_out_level;
    logic                       r_out_silent;

    logic [FW-1:0]              eff_win;
    logic signed [MAG_W-1:0]    sample_ext;
    logic [MAG_W-1:0]           mag;
    logic [2*MAG_W-1:0]         mag_sq;
    logic                       full;
    logic [FW-1:0]              wp_inc;
    logic [SUM_W-1:0]           n_sum;
    logic [LOG_IN_W-1:0]        log_x;
    logic                       log_done;
    logic [LOG_W-1:0]           log_res;
    logic signed [T_W-1:0]      n_t;
    logic signed [PROD_W-1:0]   n_prod;
    logic [PROD_W:0]            lvl_total;
    logic signed [LVL_FULL_W-1:0] lvl_full;
    logic signed [LVL_FULL_W-1:0] lvl_sat;
    logic                       sum_zero;
    logic                       out_full;

    always_comb begin
        if (r_win == '0) begin
            eff_win = FW'(1);
        end else if (32'(r_win) > WINDOW_MAX) begin
            eff_win = FW'(WINDOW_MAX);
        end else begin
            eff_win = FW'(r_win);
        end
    end

    assign sample_ext = MAG_W'(r_sample);
    assign mag        = sample_ext[MAG_W-1] ? MAG_W'(-sample_ext) : MAG_W'(sample_ext);
    assign mag_sq     = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};

    assign full   = (r_fill >= eff_win);
    assign wp_inc = FW'(r_wp) + FW'(1);
    assign n_sum  = r_sum - (full ? SUM_W'(r_rd) : '0) + SUM_W'(r_sq);

    assign log_x = i_cmd.log_sel_w ? LOG_IN_W'(eff_win) : LOG_IN_W'(r_sum);

    slrm_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.log_start),
        .i_x      (log_x),
        .o_done   (log_done),
        .o_result (log_res)
    );

    assign n_t    = $signed(T_W'(log_res)) - $signed(T_W'(r_log_w)) - T_OFS;
    assign n_prod = PROD_W'(r_t) * PROD_W'(KDB);

    always_comb begin
        lvl_total = {r_prod[PROD_W-1], r_prod} + LVL_BIAS;
        lvl_full  = $signed(lvl_total[PROD_W:FRAC_W]);
        if (sum_zero || lvl_full < LEVEL_LO) begin
            lvl_sat = LEVEL_LO;
        end else if (lvl_full > LEVEL_HI) begin
            lvl_sat = LEVEL_HI;
        end else begin
            lvl_sat = lvl_full;
        end
    end

    assign sum_zero = (r_sum == '0);
    assign out_full = r_out_valid && !i_out_ready;

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_wp] <= r_sq;
        end
        if (i_cmd.read) begin
            r_rd <= r_ring[r_wp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= WIN_RESET;
            r_sum  <= '0;
            r_fill <= '0;
            r_wp   <= '0;
        end else if (i_cfg_we) begin
            r_win  <= i_cfg_wdata;
            r_sum  <= '0;
            r_fill <= '0;
            r_wp   <= '0;
        end else if (i_cmd.update) begin
            r_sum <= n_sum;
            if (!full) begin
                r_fill <= r_fill + FW'(1);
            end
            r_wp <= (wp_inc >= eff_win) ? '0 : PW'(wp_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.read) begin
            r_sq <= mag_sq[SQ_W-1:0];
        end
        if (i_cmd.save_log_w) begin
            r_log_w <= log_res;
        end
        if (i_cmd.calc_t) begin
            r_t <= n_t;
        end
        if (i_cmd.calc_prod) begin
            r_prod <= n_prod;
        end
        if (i_cmd.load_out) begin
            r_out_sum    <= r_sum;
            r_out_level  <= LEVEL_W'(lvl_sat);
            r_out_silent <= sum_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.log_done = log_done;
    assign o_status.sum_zero = sum_zero;
    assign o_status.out_full = out_full;

    assign o_out_valid  = r_out_valid;
    assign o_window_sum = r_out_sum;
    assign o_level_dbfs = r_out_level;
    assign o_silent     = r_out_silent;

    a_wp_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FW'(r_wp) < eff_win)
        else $error("write pointer outside the window");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_win)
        else $error("fill count beyond the window");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && !i_out_ready))
        else $error("output register overwritten before transfer");

endmodule

/* sv/slrm_ctrl.sv */
// Controller state machine sequencing ring update, log conversion and result hand-off.
module slrm_ctrl
    import slrm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WSTART;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_WSTART: n_state = S_WWAIT;
            S_WWAIT: begin
                if (i_status.log_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_CHECK;
            S_CHECK:  n_state = i_status.sum_zero ? S_OUT : S_LWAIT;
            S_LWAIT: begin
                if (i_status.log_done) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_OUT;
            S_OUT: begin
                if (!i_status.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_WSTART;
        endcase
        if (i_cfg_we) begin
            n_state = S_WSTART;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_WSTART: begin
                o_cmd.log_start = 1'b1;
                o_cmd.log_sel_w = 1'b1;
            end
            S_WWAIT: begin
                o_cmd.save_log_w = i_status.log_done;
            end
            S_IDLE: begin
                o_in_ready   = !i_cfg_we;
                o_cmd.accept = i_in_valid && !i_cfg_we;
            end
            S_READ:   o_cmd.read      = 1'b1;
            S_UPDATE: o_cmd.update    = 1'b1;
            S_CHECK:  o_cmd.log_start = !i_status.sum_zero;
            S_LWAIT:  o_cmd           = '0;
            S_DIFF:   o_cmd.calc_t    = 1'b1;
            S_MUL:    o_cmd.calc_prod = 1'b1;
            S_OUT:    o_cmd.load_out  = !i_status.out_full;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

/* sv/sliding_rms_level_meter.sv */
// Top level: sliding-window RMS level meter with dBFS output.
// A sample passes READ, UPDATE, CHECK, the log2 wait, DIFF, MUL and OUT before its result is valid;
// a zero window sum skips from CHECK to OUT. A new sample is accepted only back in IDLE (22-step log2 unit).
// The result register lets the next sample transfer in while a result waits.
// Reset (sync, active low) and window length writes clear the meter; log2(window) is then
// recomputed before the first sample transfer is accepted.
module sliding_rms_level_meter
    import slrm_pkg::*;
#(
    parameter int WINDOW_MAX = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [SUM_W-1:0]           o_window_sum,
    output logic signed [LEVEL_W-1:0]  o_level_dbfs,
    output logic                       o_silent
);

    t_cmd    cmd;
    t_status status;

    slrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    slrm_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_sample),
        .i_out_ready  (i_out_ready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_window_sum (o_window_sum),
        .o_level_dbfs (o_level_dbfs),
        .o_silent     (o_silent)
    );

endmodule
